### rtl/core/gdd_pkg.sv
// Shared constants, tables and types for the Gregorian date difference pipeline.
`timescale 1ns / 1ps
`default_nettype none

package gdd_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned CountW  = 22;
  localparam int unsigned QuotW   = 8;   // floor(year / 100) for any 14-bit year
  localparam int unsigned MStartW = 9;

  localparam logic [YearW-1:0] YearMin = 14'd1;
  localparam logic [YearW-1:0] YearMax = 14'd9999;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  // ceil(2^19 / 100): exact floor(x / 100) for every x below 43690.
  localparam int unsigned Recip100Shift = 19;
  localparam logic [12:0] Recip100      = 13'd5243;
  localparam logic [YearW-1:0] Hundred  = 14'd100;
  localparam logic [22:0] DaysCommonYear = 23'd365;

  // Stage enables of one serial-day unit.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } gdd_en_t;

  // Length of a month in a common year; zero for codes that are no month.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the first of a month in a common year.
  function automatic logic [MStartW-1:0] month_start(input logic [MonthW-1:0] m);
    logic [MStartW-1:0] ms;
    case (m)
      4'd2:    ms = 9'd31;
      4'd3:    ms = 9'd59;
      4'd4:    ms = 9'd90;
      4'd5:    ms = 9'd120;
      4'd6:    ms = 9'd151;
      4'd7:    ms = 9'd181;
      4'd8:    ms = 9'd212;
      4'd9:    ms = 9'd243;
      4'd10:   ms = 9'd273;
      4'd11:   ms = 9'd304;
      4'd12:   ms = 9'd334;
      default: ms = 9'd0;
    endcase
    return ms;
  endfunction

endpackage

`default_nettype wire

### rtl/core/gdd_serial_day.sv
// Three-stage unit that checks one date and turns it into a serial day number.
`timescale 1ns / 1ps
`default_nettype none

module gdd_serial_day (
  input  wire logic                      clk_i,
  input  wire gdd_pkg::gdd_en_t          en_i,
  input  wire logic [gdd_pkg::YearW-1:0] year_i,
  input  wire logic [gdd_pkg::MonthW-1:0] month_i,
  input  wire logic [gdd_pkg::DayW-1:0]  day_i,
  output logic                           ok_o,
  output logic [gdd_pkg::CountW-1:0]     serial_o
);
  import gdd_pkg::*;

  // Stage 1: previous year and the two reciprocal multiplications.
  logic [YearW-1:0]  y1_q, p1_q, p1_d;
  logic [MonthW-1:0] m1_q;
  logic [DayW-1:0]   d1_q;
  logic [QuotW-1:0]  qy1_q, qy1_d, qp1_q, qp1_d;
  logic [26:0]       prod_y, prod_p;

  always_comb begin
    p1_d   = year_i - 14'd1;
    prod_y = {13'd0, year_i} * {14'd0, Recip100};
    prod_p = {13'd0, p1_d} * {14'd0, Recip100};
    qy1_d  = prod_y[Recip100Shift +: QuotW];
    qp1_d  = prod_p[Recip100Shift +: QuotW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      y1_q  <= year_i;
      p1_q  <= p1_d;
      m1_q  <= month_i;
      d1_q  <= day_i;
      qy1_q <= qy1_d;
      qp1_q <= qp1_d;
    end
  end

  // Stage 2: leap rule, validity, whole-year days and month offset.
  logic [YearW-1:0]   rem100;
  logic [YearW-1:0]   hund_mul;
  logic               leap;
  logic               year_ok, month_ok, day_ok;
  logic [DayW-1:0]    mlen;
  logic [22:0]        p365;
  logic               ok2_q, ok2_d;
  logic [CountW-1:0]  base2_q, base2_d;
  logic [QuotW-1:0]   corr2_q, corr2_d;
  logic [MStartW-1:0] moff2_q, moff2_d;
  logic [DayW-1:0]    d2_q;

  always_comb begin
    hund_mul = {6'd0, qy1_q} * Hundred;
    rem100   = y1_q - hund_mul;
    // A century year is a leap year only when its century count is a multiple of four.
    leap     = (y1_q[1:0] == 2'd0) && ((rem100 != '0) || (qy1_q[1:0] == 2'd0));
    year_ok  = (y1_q >= YearMin) && (y1_q <= YearMax);
    month_ok = (m1_q >= MonthJan) && (m1_q <= MonthDec);
    mlen     = month_len(m1_q) + {4'd0, (m1_q == MonthFeb) && leap};
    day_ok   = (d1_q != '0) && (d1_q <= mlen);
    ok2_d    = year_ok && month_ok && day_ok;
    p365     = {9'd0, p1_q} * DaysCommonYear;
    base2_d  = p365[CountW-1:0] + {10'd0, p1_q[YearW-1:2]};
    corr2_d  = qp1_q - {2'd0, qp1_q[QuotW-1:2]};
    moff2_d  = month_start(m1_q) + {8'd0, (m1_q > MonthFeb) && leap};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      ok2_q   <= ok2_d;
      base2_q <= base2_d;
      corr2_q <= corr2_d;
      moff2_q <= moff2_d;
      d2_q    <= d1_q;
    end
  end

  // Stage 3: assemble the serial day number.
  logic [CountW-1:0] serial3_q, serial3_d;
  logic              ok3_q;

  always_comb begin
    serial3_d = base2_q - {14'd0, corr2_q} + {13'd0, moff2_q} + {17'd0, d2_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      ok3_q     <= ok2_q;
      serial3_q <= serial3_d;
    end
  end

  assign ok_o     = ok3_q;
  assign serial_o = serial3_q;

endmodule

`default_nettype wire

### rtl/core/gregorian_date_difference.sv
// Top level: number of days between two Gregorian dates, four-stage pipeline.
//
// Input channel: in_valid_i with the six date fields; an item is taken at a
// clock edge where in_valid_i is high and in_stall_o is low. Output channel:
// out_valid_o with day_count_o and invalid_o; a result is taken at an edge
// where out_valid_o is high and out_stall_i is low.
// Each item gives exactly one result, which moves through every register
// stage in order before it reaches the outputs. The four register stages
// are three per date (reciprocal multiply for the century count, leap
// check and year days, serial assembly) and one for the absolute
// difference. One item can be taken every cycle while the output is not
// stalled.
// A date outside years 1 to 9999, months 1 to 12 or its month's length sets
// invalid_o and forces day_count_o to zero.
// Reset empties the pipeline; data is not reset. When the receiver
// stalls, the result holds and empty stages still fill, so in_stall_o rises
// only once every stage holds an item.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_difference (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [gdd_pkg::YearW-1:0]   year_a_i,
  input  wire logic [gdd_pkg::MonthW-1:0]  month_a_i,
  input  wire logic [gdd_pkg::DayW-1:0]    day_a_i,
  input  wire logic [gdd_pkg::YearW-1:0]   year_b_i,
  input  wire logic [gdd_pkg::MonthW-1:0]  month_b_i,
  input  wire logic [gdd_pkg::DayW-1:0]    day_b_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [gdd_pkg::CountW-1:0]       day_count_o,
  output logic                             invalid_o
);
  import gdd_pkg::*;

  localparam logic [CountW-1:0] MaxCount = 22'd3652058;

  logic [3:0] v_q;
  logic [3:0] en;
  gdd_en_t    unit_en;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[3] = !v_q[3] || !out_stall_i;
    en[2] = !v_q[2] || en[3];
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
    unit_en.s1 = en[0];
    unit_en.s2 = en[1];
    unit_en.s3 = en[2];
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  logic              ok_a, ok_b;
  logic [CountW-1:0] serial_a, serial_b;

  gdd_serial_day u_date_a (
    .clk_i    (clk_i),
    .en_i     (unit_en),
    .year_i   (year_a_i),
    .month_i  (month_a_i),
    .day_i    (day_a_i),
    .ok_o     (ok_a),
    .serial_o (serial_a)
  );

  gdd_serial_day u_date_b (
    .clk_i    (clk_i),
    .en_i     (unit_en),
    .year_i   (year_b_i),
    .month_i  (month_b_i),
    .day_i    (day_b_i),
    .ok_o     (ok_b),
    .serial_o (serial_b)
  );

  logic [CountW-1:0] count_q, count_d;
  logic              invalid_q, invalid_d;

  always_comb begin
    invalid_d = !(ok_a && ok_b);
    if (invalid_d) begin
      count_d = '0;
    end else if (serial_a >= serial_b) begin
      count_d = serial_a - serial_b;
    end else begin
      count_d = serial_b - serial_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      count_q   <= count_d;
      invalid_q <= invalid_d;
    end
  end

  assign out_valid_o = v_q[3];
  assign day_count_o = count_q;
  assign invalid_o   = invalid_q;

  // An invalid result never carries a day count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> day_count_o == '0)
    else $error("invalid result with nonzero day count");

  // A valid result stays within the span of years 1 to 9999.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !invalid_o |-> day_count_o <= MaxCount)
    else $error("day count beyond the supported span");

  // The input side stalls only when every stage holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v_q == 4'b1111) && out_stall_i)
    else $error("input stalled while a stage was empty");

  // An item leaving the last date stage reaches the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] && en[3] |=> v_q[3])
    else $error("item lost between pipeline stages");

endmodule

`default_nettype wire

### test/tb_gregorian_date_difference.sv
// Self-checking testbench for the Gregorian date difference pipeline.
`timescale 1ns / 1ps

module tb_gregorian_date_difference;

  localparam int unsigned YearW  = gdd_pkg::YearW;
  localparam int unsigned MonthW = gdd_pkg::MonthW;
  localparam int unsigned DayW   = gdd_pkg::DayW;
  localparam int unsigned CountW = gdd_pkg::CountW;
  localparam int unsigned DateW  = YearW + MonthW + DayW;

  localparam int RandomPairs   = 1900;
  localparam int HoldOffCycles = 200;
  localparam int TailCycles    = 16;
  localparam int CycleLimit    = 200000;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  typedef struct {
    logic [CountW-1:0] days;
    logic              flag;
  } day_span_t;

  typedef enum int {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  // Predicts the day span of each accepted pair and checks results in order.
  class day_span_scoreboard;
    day_span_t spans_due[$];
    int pairs_noted;
    int invalid_noted;
    int results_checked;
    int mismatches;

    function bit leap(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Days before the first of month m in a common year; the last entry closes December.
    function int unsigned days_before(int unsigned m);
      int unsigned start_of [14];
      start_of = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
      return start_of[m];
    endfunction

    function int unsigned month_days(int unsigned y, int unsigned m);
      if (m < 1 || m > 12) return 0;
      return days_before(m + 1) - days_before(m) + ((m == 2 && leap(y)) ? 1 : 0);
    endfunction

    function bit date_valid(date_t dt);
      if (dt.year < 1 || dt.year > 9999) return 0;
      return (dt.day >= 1) && (dt.day <= month_days(dt.year, dt.month));
    endfunction

    // Serial day number with the first of January of year one as day one.
    function int unsigned serial_of(date_t dt);
      int unsigned p;
      int unsigned n;
      p = dt.year - 1;
      n = p * 365 + p / 4 - p / 100 + p / 400 + days_before(dt.month) + dt.day;
      if (dt.month > 2 && leap(dt.year)) n++;
      return n;
    endfunction

    function void note(date_t a, date_t b);
      day_span_t   s;
      int unsigned sa;
      int unsigned sb;
      pairs_noted++;
      if (!date_valid(a) || !date_valid(b)) begin
        s.days = '0;
        s.flag = 1'b1;
        invalid_noted++;
      end else begin
        sa = serial_of(a);
        sb = serial_of(b);
        s.days = CountW'((sa >= sb) ? sa - sb : sb - sa);
        s.flag = 1'b0;
      end
      spans_due.push_back(s);
    endfunction

    function void check(logic [CountW-1:0] days, logic flag);
      day_span_t s;
      results_checked++;
      if (spans_due.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: result day_count=%0d invalid=%0b arrived with no item pending",
                   days, flag);
        mismatches++;
        return;
      end
      s = spans_due.pop_front();
      if (days !== s.days || flag !== s.flag) begin
        if (mismatches < 10)
          $display({"ERROR: result %0d: day_count expected %0d got %0d, ",
                    "invalid expected %0b got %0b"},
                   results_checked, s.days, days, s.flag, flag);
        mismatches++;
      end
    endfunction

    function int pending();
      return spans_due.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [YearW-1:0]  year_a_i;
  logic [MonthW-1:0] month_a_i;
  logic [DayW-1:0]   day_a_i;
  logic [YearW-1:0]  year_b_i;
  logic [MonthW-1:0] month_b_i;
  logic [DayW-1:0]   day_b_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [CountW-1:0] day_count_o;
  logic              invalid_o;

  day_span_scoreboard board = new();

  int cycle_count;
  int input_stall_cycles;
  int holdoffs_done;
  bit holdoff_request;
  int holdoff_left;

  gregorian_date_difference dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .year_a_i    (year_a_i),
    .month_a_i   (month_a_i),
    .day_a_i     (day_a_i),
    .year_b_i    (year_b_i),
    .month_b_i   (month_b_i),
    .day_b_i     (day_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .day_count_o (day_count_o),
    .invalid_o   (invalid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, board.pending());
    $display("tb_gregorian_date_difference: FAIL");
    $finish;
  end

  // Receiver: switches between stall patterns and honors long hold-off requests.
  initial begin : receiver
    stall_mode_e mode;
    int          mode_left;
    int          phase;
    bit          stall;
    out_stall_i  = 1'b0;
    holdoff_left = 0;
    mode         = StallNone;
    mode_left    = 50;
    phase        = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_request) begin
        holdoff_left    = HoldOffCycles;
        holdoff_request = 1'b0;
        holdoffs_done++;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      phase++;
      if (holdoff_left > 0) begin
        stall = 1'b1;
        holdoff_left--;
      end else begin
        case (mode)
          StallNone:  stall = 1'b0;
          StallLight: stall = ($urandom_range(0, 9) < 2);
          StallHeavy: stall = ($urandom_range(0, 9) < 7);
          default:    stall = ((phase % 7) < 3);
        endcase
      end
      out_stall_i = stall;
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) board.check(day_count_o, invalid_o);
    end
  end

  function automatic date_t mk(int y, int m, int d);
    date_t r;
    r.year  = YearW'(y);
    r.month = MonthW'(m);
    r.day   = DayW'(d);
    return r;
  endfunction

  // Mostly well-formed dates, some just past a month's end, some raw bits.
  function automatic date_t pick_date();
    date_t       r;
    int unsigned sel;
    int unsigned len;
    sel = $urandom_range(0, 19);
    if (sel < 2) begin
      {r.year, r.month, r.day} = DateW'($urandom);
      return r;
    end
    case ($urandom_range(0, 4))
      0: r.year = YearW'(100 * $urandom_range(1, 99));
      1: r.year = YearW'($urandom_range(0, 1) ? $urandom_range(1, 3)
                                              : $urandom_range(9997, 9999));
      default: r.year = YearW'($urandom_range(1, 9999));
    endcase
    r.month = MonthW'($urandom_range(1, 12));
    len = board.month_days(r.year, r.month);
    if (sel < 4) begin
      if ($urandom_range(0, 1)) begin
        r.day = DayW'(len + 1);
      end else begin
        // February 29 of a year that is not a multiple of four.
        r.year  = YearW'(4 * $urandom_range(0, 2499) + $urandom_range(1, 3));
        r.month = MonthW'(2);
        r.day   = DayW'(29);
      end
    end else begin
      r.day = DayW'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
    end
    return r;
  endfunction

  task automatic send_pair(input date_t a, input date_t b);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    year_a_i   = a.year;
    month_a_i  = a.month;
    day_a_i    = a.day;
    year_b_i   = b.year;
    month_b_i  = b.month;
    day_b_i    = b.day;
    @(posedge clk_i);
    while (in_stall_o) begin
      input_stall_cycles++;
      @(posedge clk_i);
    end
    board.note(a, b);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int target;
    int next_squeeze;
    int burst;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    year_a_i   = '0;
    month_a_i  = '0;
    day_a_i    = '0;
    year_b_i   = '0;
    month_b_i  = '0;
    day_b_i    = '0;
    holdoff_request    = 1'b0;
    input_stall_cycles = 0;
    holdoffs_done      = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: equal dates, full span both ways, field extremes and leap rules.
    send_pair(mk(2000, 2, 29), mk(2000, 2, 29));
    send_pair(mk(1, 1, 1), mk(9999, 12, 31));
    send_pair(mk(9999, 12, 31), mk(1, 1, 1));
    send_pair(mk(0, 1, 1), mk(2020, 5, 5));
    send_pair(mk(2020, 5, 5), mk(10000, 1, 1));
    send_pair(mk(16383, 15, 31), mk(1, 1, 1));
    send_pair(mk(1999, 0, 10), mk(1999, 10, 10));
    send_pair(mk(1999, 13, 1), mk(1999, 1, 1));
    send_pair(mk(1999, 1, 1), mk(1999, 15, 1));
    send_pair(mk(2001, 6, 0), mk(2001, 6, 1));
    send_pair(mk(2001, 4, 31), mk(2001, 5, 1));
    send_pair(mk(2001, 1, 31), mk(2001, 12, 31));
    send_pair(mk(1900, 2, 29), mk(1900, 3, 1));
    send_pair(mk(2000, 2, 29), mk(2000, 3, 1));
    send_pair(mk(2023, 2, 29), mk(2024, 2, 29));
    send_pair(mk(2024, 2, 29), mk(2023, 2, 28));
    send_pair(mk(2024, 3, 1), mk(2024, 2, 28));
    send_pair(mk(2100, 2, 28), mk(2100, 3, 1));
    send_pair(mk(9999, 1, 1), mk(9999, 12, 31));
    send_pair(mk(0, 0, 0), mk(0, 0, 0));
    send_pair(mk(1, 1, 1), mk(1, 1, 1));
    idle_for(1);
    drain_results();

    target       = board.pairs_noted + RandomPairs;
    next_squeeze = board.pairs_noted + 500;
    while (board.pairs_noted < target) begin
      if (board.pairs_noted >= next_squeeze) begin
        // Hold the output off long enough for the pipeline to fill and push back.
        holdoff_request = 1'b1;
        repeat (40) send_pair(pick_date(), pick_date());
        idle_for(1);
        drain_results();
        next_squeeze += 700;
      end
      burst = $urandom_range(1, 30);
      repeat (burst) send_pair(pick_date(), pick_date());
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
    end

    idle_for(1);
    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d date pairs (%0d flagged invalid), %0d results checked, %0d mismatches",
             board.pairs_noted, board.invalid_noted, board.results_checked, board.mismatches);
    $display("Input pushed back on %0d cycles; %0d long output hold-offs; %0d cycles run",
             input_stall_cycles, holdoffs_done, cycle_count);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_gregorian_date_difference: PASS");
    end else begin
      $display("tb_gregorian_date_difference: FAIL");
    end
    $finish;
  end

endmodule
